>>> hw/rtl/svce_pkg.sv
package svce_pkg;

  localparam logic [2:0] KIND_MASTER = 3'd0;
  localparam logic [2:0] KIND_FRONT  = 3'd1;
  localparam logic [2:0] KIND_REAR   = 3'd2;
  localparam logic [2:0] KIND_CENTER = 3'd3;
  localparam logic [2:0] KIND_SUB    = 3'd4;

  localparam logic [6:0]        VOL_MAX   = 7'd79;
  localparam logic signed [7:0] TRIM_SKIP = -8'sd22;
  localparam logic signed [7:0] TRIM_MUTE = -8'sd20;

  localparam int NUM_CMDS = 6;

  // channel slots: all, sub, center, rear a, rear b, front a, front b
  localparam logic [7:0] TENS_CODE [7] = '{8'hd0, 8'h80, 8'h40, 8'h00, 8'h20, 8'h60, 8'ha0};
  localparam logic [7:0] UNITS_CODE [7] = '{8'he0, 8'h90, 8'h50, 8'h10, 8'h30, 8'h70, 8'hb0};

  typedef struct packed {
    logic [6:0] master;
    logic [7:0] front;
    logic [7:0] rear;
    logic [7:0] center;
    logic [7:0] sub;
  } svce_state_t;

  typedef struct packed {
    logic                          all;
    logic [NUM_CMDS-1:0][7:0]      tens;
    logic [NUM_CMDS-1:0][7:0]      units;
  } svce_batch_t;

endpackage

>>> hw/rtl/surround_volume_command_encoder.sv
// Surround volume command encoder. Each input transfer sets the master volume
// (s_tuser = 0) or the front, rear, center or subwoofer offset (s_tuser = 1..4)
// and yields the volume-chip command bytes for the new settings, one byte per
// cycle while m_tready is high: 4 bytes when every channel equals the master,
// otherwise 24 bytes (sub, center, rear, rear, front, front). An offset of -22
// and an unknown kind change nothing and yield no bytes. Inputs are taken into
// a one-entry register while the previous bytes are still going out; the level
// math is done in one pass and loaded into the byte serializer as its last
// byte leaves, so the sustained input rate is set by the serializer's output.
module surround_volume_command_encoder import svce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] value (signed)
  input  logic [2:0] s_tuser,   // [2:0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] cmd_byte
  output logic       m_tuser,   // [0] stop_after
  output logic       m_tlast
);

  logic              in_valid;
  logic [2:0]        in_kind;
  logic signed [7:0] in_value;
  svce_state_t       state;
  svce_state_t       state_next;
  svce_batch_t       batch;
  logic              emit;
  logic              ser_ready;
  logic              in_take;

  assign in_take  = in_valid && (!emit || ser_ready);
  assign s_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind  <= s_tuser;
      in_value <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  svce_levels u_levels (
    .state      (state),
    .kind       (in_kind),
    .value      (in_value),
    .state_next (state_next),
    .emit       (emit),
    .batch      (batch)
  );

  svce_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (in_take && emit),
    .batch_in (batch),
    .ready    (ser_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hw/rtl/svce_levels.sv
module svce_levels import svce_pkg::*; (
  input  svce_state_t       state,
  input  logic [2:0]        kind,
  input  logic signed [7:0] value,
  output svce_state_t       state_next,
  output logic              emit,
  output svce_batch_t       batch
);

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  function automatic logic [6:0] chan_level(input logic [6:0] master, input logic [7:0] trim);
    logic signed [9:0] sum;
    logic [6:0]        lvl;
    sum = $signed({3'b000, master}) + $signed({{2{trim[7]}}, trim});
    if (($signed(trim) < TRIM_MUTE) || (master == 7'd0) || (sum < 10'sd0)) begin
      lvl = 7'd0;
    end else if (sum > $signed({3'b000, VOL_MAX})) begin
      lvl = VOL_MAX;
    end else begin
      lvl = sum[6:0];
    end
    return lvl;
  endfunction

  // attenuation split by reciprocal multiply, exact for att < 80
  function automatic digits_t split_att(input logic [6:0] lvl);
    logic [6:0]  att;
    logic [13:0] prod;
    logic [2:0]  t;
    logic [6:0]  tx10;
    digits_t     d;
    att    = VOL_MAX - lvl;
    prod   = {7'd0, att} * 14'd205;
    t      = prod[13:11];
    tx10   = {4'd0, t} * 7'd10;
    d.tens  = {1'b0, t};
    d.units = 4'(att - tx10);
    return d;
  endfunction

  logic [6:0] sat_master;
  logic [6:0] lvl_f, lvl_r, lvl_c, lvl_s;
  logic       all_same;
  digits_t    dig_m, dig_f, dig_r, dig_c, dig_s;

  always_comb begin
    if (value < 8'sd0) begin
      sat_master = 7'd0;
    end else if (value > $signed({1'b0, VOL_MAX})) begin
      sat_master = VOL_MAX;
    end else begin
      sat_master = value[6:0];
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    case (kind)
      KIND_MASTER: begin
        state_next.master = sat_master;
        emit              = 1'b1;
      end
      KIND_FRONT: begin
        if (value != TRIM_SKIP) begin
          state_next.front = value;
          emit             = 1'b1;
        end
      end
      KIND_REAR: begin
        if (value != TRIM_SKIP) begin
          state_next.rear = value;
          emit            = 1'b1;
        end
      end
      KIND_CENTER: begin
        if (value != TRIM_SKIP) begin
          state_next.center = value;
          emit              = 1'b1;
        end
      end
      KIND_SUB: begin
        if (value != TRIM_SKIP) begin
          state_next.sub = value;
          emit           = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign lvl_f = chan_level(state_next.master, state_next.front);
  assign lvl_r = chan_level(state_next.master, state_next.rear);
  assign lvl_c = chan_level(state_next.master, state_next.center);
  assign lvl_s = chan_level(state_next.master, state_next.sub);

  assign all_same = (lvl_f == state_next.master) && (lvl_r == state_next.master) &&
                    (lvl_c == state_next.master) && (lvl_s == state_next.master);

  assign dig_m = split_att(state_next.master);
  assign dig_f = split_att(lvl_f);
  assign dig_r = split_att(lvl_r);
  assign dig_c = split_att(lvl_c);
  assign dig_s = split_att(lvl_s);

  always_comb begin
    batch.all = all_same;
    if (all_same) begin
      batch.tens[0]  = TENS_CODE[0]  | {4'd0, dig_m.tens};
      batch.units[0] = UNITS_CODE[0] | {4'd0, dig_m.units};
    end else begin
      batch.tens[0]  = TENS_CODE[1]  | {4'd0, dig_s.tens};
      batch.units[0] = UNITS_CODE[1] | {4'd0, dig_s.units};
    end
    batch.tens[1]  = TENS_CODE[2]  | {4'd0, dig_c.tens};
    batch.units[1] = UNITS_CODE[2] | {4'd0, dig_c.units};
    batch.tens[2]  = TENS_CODE[3]  | {4'd0, dig_r.tens};
    batch.units[2] = UNITS_CODE[3] | {4'd0, dig_r.units};
    batch.tens[3]  = TENS_CODE[4]  | {4'd0, dig_r.tens};
    batch.units[3] = UNITS_CODE[4] | {4'd0, dig_r.units};
    batch.tens[4]  = TENS_CODE[5]  | {4'd0, dig_f.tens};
    batch.units[4] = UNITS_CODE[5] | {4'd0, dig_f.units};
    batch.tens[5]  = TENS_CODE[6]  | {4'd0, dig_f.tens};
    batch.units[5] = UNITS_CODE[6] | {4'd0, dig_f.units};
  end

endmodule

>>> hw/rtl/svce_serializer.sv
module svce_serializer import svce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  svce_batch_t batch_in,
  output logic        ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  svce_batch_t batch;
  logic        valid;
  logic [4:0]  cnt;
  logic        last_byte;
  logic [2:0]  idx;

  assign last_byte = batch.all ? (cnt == 5'd3) : (cnt == 5'd23);
  assign ready     = !valid || (m_tready && last_byte);
  assign idx       = cnt[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= 5'd0;
    end else if (load) begin
      valid <= 1'b1;
      cnt   <= 5'd0;
    end else if (valid && m_tready) begin
      if (last_byte) begin
        valid <= 1'b0;
      end else begin
        cnt <= cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch <= batch_in;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = cnt[0] ? batch.units[idx] : batch.tens[idx];
  assign m_tuser  = cnt[0];
  assign m_tlast  = last_byte;

endmodule

>>> hw/rtl/svce_checker.sv
module svce_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  // no output right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a tens byte is always followed by its units byte
  a_tens_units: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tuser) |=> (m_tvalid && m_tuser))
    else $error("tens byte not followed by units byte");

  // inside a run, a units byte is followed by a tens byte
  a_units_tens: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser && !m_tlast) |=> (m_tvalid && !m_tuser))
    else $error("units byte not followed by tens byte");

  // a run ends on a units byte
  a_last_units: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("last byte is not a units byte");

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tlast) && $stable(m_tdata)))
    else $error("stalled output changed");

endmodule

bind surround_volume_command_encoder svce_checker u_svce_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
